### hdl/pts_pkg.sv
package pts_pkg;

  localparam int unsigned TABLE_ROWS = 8;
  localparam int unsigned COIL_COUNT = 4;
  localparam int unsigned ROW_W      = $clog2(TABLE_ROWS);
  localparam int unsigned COIL_W     = $clog2(COIL_COUNT);
  localparam int unsigned RUNS_W     = 14;
  localparam int unsigned STEPS_W    = 16;
  localparam int unsigned MAXC_W     = 10;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned NRUNS_W    = 5;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [RUNS_W-1:0] RUNS_MAX = '1;

  // register indexes on the write port
  localparam logic [REG_IDX_W-1:0] REG_COUNT_LIMIT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEP_PERIOD = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAN_RUNS    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TILT_RUNS   = 2'd3;

  localparam logic [MAXC_W-1:0]   COUNT_LIMIT_RST = 10'd10;
  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 16'd250;
  localparam logic [NRUNS_W-1:0]  PAN_RUNS_RST    = 5'd8;
  localparam logic [NRUNS_W-1:0]  TILT_RUNS_RST   = 5'd4;

  typedef struct packed {
    logic [MAXC_W-1:0]   count_limit;
    logic [PERIOD_W-1:0] step_period;
    logic [NRUNS_W-1:0]  pan_runs;
    logic [NRUNS_W-1:0]  tilt_runs;
  } cfg_t;

  typedef struct packed {
    logic [COIL_COUNT-1:0] pan_coils;
    logic [COIL_COUNT-1:0] tilt_coils;
    logic                  busy;
    logic                  done;
    logic                  rejected;
  } result_t;

  // half-step coil pattern, bit0 is the first coil
  function automatic logic [COIL_COUNT-1:0] half_step(input logic [ROW_W-1:0] row);
    logic [COIL_COUNT-1:0] pat;
    case (row)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

  function automatic logic [MAXC_W-1:0] clamp_mag(input logic [STEPS_W-1:0] v,
                                                 input logic [MAXC_W-1:0]  lim);
    logic [STEPS_W-1:0] mag;
    mag = v[STEPS_W-1] ? STEPS_W'(-v) : v;
    return (mag > {{(STEPS_W-MAXC_W){1'b0}}, lim}) ? lim : mag[MAXC_W-1:0];
  endfunction

  // magnitude times runs, saturated to the pass counter range
  function automatic logic [RUNS_W-1:0] pass_total(input logic [MAXC_W-1:0]  mag,
                                                  input logic [NRUNS_W-1:0] runs);
    logic [MAXC_W+NRUNS_W-1:0] prod;
    prod = {{NRUNS_W{1'b0}}, mag} * {{MAXC_W{1'b0}}, runs};
    return (prod > (MAXC_W+NRUNS_W)'(RUNS_MAX)) ? RUNS_MAX : prod[RUNS_W-1:0];
  endfunction

endpackage

### hdl/pts_step.sv
module pts_step
  import pts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  logic                      action,
  input  logic signed [STEPS_W-1:0] pan_steps,
  input  logic signed [STEPS_W-1:0] tilt_steps,
  input  cfg_t                      cfg,
  output result_t                   res
);

  typedef enum logic [1:0] {PH_IDLE, PH_PAN, PH_TILT, PH_FINISH} phase_t;

  phase_t                phase, phase_next;
  logic [RUNS_W-1:0]     runs_left, runs_left_next;
  logic [RUNS_W-1:0]     tilt_pending, tilt_pending_next;
  logic [ROW_W-1:0]      table_row, table_row_next;
  logic [COIL_W-1:0]     coil_index, coil_index_next;
  logic [PERIOD_W-1:0]   delay_count, delay_count_next;
  logic                  pan_reverse, pan_reverse_next;
  logic                  tilt_reverse, tilt_reverse_next;
  logic [COIL_COUNT-1:0] pan_coil, pan_coil_next;
  logic [COIL_COUNT-1:0] tilt_coil, tilt_coil_next;

  logic [RUNS_W-1:0]     pan_pass, tilt_pass;
  logic [PERIOD_W-1:0]   reload;
  logic                  rev_sel;
  logic [ROW_W-1:0]      row_sel;
  logic [COIL_COUNT-1:0] row_pat;
  logic                  coil_bit;
  logic                  done, rejected;

  assign pan_pass  = pass_total(clamp_mag(pan_steps, cfg.count_limit), cfg.pan_runs);
  assign tilt_pass = pass_total(clamp_mag(tilt_steps, cfg.count_limit), cfg.tilt_runs);
  assign reload    = (cfg.step_period == '0) ? '0 : cfg.step_period - 1'b1;
  assign rev_sel   = (phase == PH_PAN) ? pan_reverse : tilt_reverse;
  assign row_sel   = rev_sel ? ~table_row : table_row;
  assign row_pat   = half_step(row_sel);
  assign coil_bit  = row_pat[coil_index];

  always_comb begin
    phase_next        = phase;
    runs_left_next    = runs_left;
    tilt_pending_next = tilt_pending;
    table_row_next    = table_row;
    coil_index_next   = coil_index;
    delay_count_next  = delay_count;
    pan_reverse_next  = pan_reverse;
    tilt_reverse_next = tilt_reverse;
    pan_coil_next     = pan_coil;
    tilt_coil_next    = tilt_coil;
    done              = 1'b0;
    rejected          = 1'b0;

    if (action) begin
      if (phase != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        pan_reverse_next  = pan_steps[STEPS_W-1];
        tilt_reverse_next = ~tilt_steps[STEPS_W-1];
        pan_coil_next     = '0;
        tilt_coil_next    = '0;
        table_row_next    = '0;
        coil_index_next   = '0;
        delay_count_next  = '0;
        if (pan_pass != '0) begin
          phase_next        = PH_PAN;
          runs_left_next    = pan_pass;
          tilt_pending_next = tilt_pass;
        end else if (tilt_pass != '0) begin
          phase_next        = PH_TILT;
          runs_left_next    = tilt_pass;
          tilt_pending_next = '0;
        end else begin
          runs_left_next    = '0;
          tilt_pending_next = '0;
          done              = 1'b1;
        end
      end
    end else if (phase != PH_IDLE) begin
      if (delay_count != '0) begin
        delay_count_next = delay_count - 1'b1;
      end else if (phase == PH_FINISH) begin
        pan_coil_next   = '0;
        tilt_coil_next  = '0;
        phase_next      = PH_IDLE;
        runs_left_next  = '0;
        table_row_next  = '0;
        coil_index_next = '0;
        done            = 1'b1;
      end else begin
        // write one coil bit, then advance coil, row and pass counters
        if (phase == PH_PAN) begin
          pan_coil_next[coil_index] = coil_bit;
        end else begin
          tilt_coil_next[coil_index] = coil_bit;
        end
        coil_index_next  = coil_index + 1'b1;
        delay_count_next = reload;
        if (coil_index == COIL_W'(COIL_COUNT - 1)) begin
          table_row_next = table_row + 1'b1;
          if (table_row == ROW_W'(TABLE_ROWS - 1)) begin
            runs_left_next = runs_left - 1'b1;
            if (runs_left == RUNS_W'(1)) begin
              if (phase == PH_PAN && tilt_pending != '0) begin
                phase_next        = PH_TILT;
                runs_left_next    = tilt_pending;
                tilt_pending_next = '0;
              end else begin
                phase_next = PH_FINISH;
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    res.pan_coils  = pan_coil_next;
    res.tilt_coils = tilt_coil_next;
    res.busy       = (phase_next != PH_IDLE);
    res.done       = done;
    res.rejected   = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      runs_left    <= '0;
      tilt_pending <= '0;
      table_row    <= '0;
      coil_index   <= '0;
      delay_count  <= '0;
      pan_reverse  <= 1'b0;
      tilt_reverse <= 1'b0;
      pan_coil     <= '0;
      tilt_coil    <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      runs_left    <= runs_left_next;
      tilt_pending <= tilt_pending_next;
      table_row    <= table_row_next;
      coil_index   <= coil_index_next;
      delay_count  <= delay_count_next;
      pan_reverse  <= pan_reverse_next;
      tilt_reverse <= tilt_reverse_next;
      pan_coil     <= pan_coil_next;
      tilt_coil    <= tilt_coil_next;
    end
  end

endmodule

### hdl/pan_tilt_half_step_sequencer.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  action, pan_steps, tilt_steps
// output    out        out_valid / out_stall pan_coils, tilt_coils, busy_res,
//                                           move_done, start_rejected
// config    in         wr_en                wr_index, wr_data
//
// One transaction in and one out per clock when nothing stalls.
// A taken input first sits in the input register, which feeds the sequencer;
// the sequencer's update lands in the result register when the input advances.
// rst is synchronous: sequencer coil state off, sequencer idle, registers back to defaults.
// out_stall holds the result register and, through it, the input register;
// in_stall rises only while the input register is full and cannot move on.
module pan_tilt_half_step_sequencer
  import pts_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic signed [STEPS_W-1:0]  pan_steps,
  input  logic signed [STEPS_W-1:0]  tilt_steps,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [COIL_COUNT-1:0]      pan_coils,
  output logic [COIL_COUNT-1:0]      tilt_coils,
  output logic                       busy_res,
  output logic                       move_done,
  output logic                       start_rejected,
  input  logic                       wr_en,
  input  logic [REG_IDX_W-1:0]       wr_index,
  input  logic [PERIOD_W-1:0]        wr_data
);

  cfg_t                      cfg;
  logic                      in_vld;
  logic                      in_action;
  logic signed [STEPS_W-1:0] in_pan;
  logic signed [STEPS_W-1:0] in_tilt;
  logic                      out_vld;
  result_t                   out_res;
  result_t                   res;
  logic                      advance;

  assign advance  = in_vld && (!out_vld || !out_stall);
  assign in_stall = in_vld && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_limit <= COUNT_LIMIT_RST;
      cfg.step_period <= STEP_PERIOD_RST;
      cfg.pan_runs    <= PAN_RUNS_RST;
      cfg.tilt_runs   <= TILT_RUNS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_COUNT_LIMIT: cfg.count_limit <= wr_data[MAXC_W-1:0];
        REG_STEP_PERIOD: cfg.step_period <= wr_data;
        REG_PAN_RUNS:    cfg.pan_runs    <= wr_data[NRUNS_W-1:0];
        REG_TILT_RUNS:   cfg.tilt_runs   <= wr_data[NRUNS_W-1:0];
        default:         cfg             <= cfg;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_action <= action;
      in_pan    <= pan_steps;
      in_tilt   <= tilt_steps;
    end
  end

  pts_step u_step (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .action     (in_action),
    .pan_steps  (in_pan),
    .tilt_steps (in_tilt),
    .cfg        (cfg),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (!out_stall) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign out_valid      = out_vld;
  assign pan_coils      = out_res.pan_coils;
  assign tilt_coils     = out_res.tilt_coils;
  assign busy_res       = out_res.busy;
  assign move_done      = out_res.done;
  assign start_rejected = out_res.rejected;

endmodule

### bench/pan_tilt_half_step_sequencer_tb.sv
`timescale 1ns / 100ps

module pan_tilt_half_step_sequencer_tb;
  import pts_pkg::*;

  // row r of the half-step table sits in bits [4r+3:4r]
  localparam logic [31:0] COIL_PATTERN = 32'h98C46231;
  localparam int HOLD_AT       = 1500;
  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 20;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_PAN, SEQ_TILT, SEQ_FINISH} seq_phase_t;

  class coil_scoreboard;
    logic [MAXC_W-1:0]     count_limit;
    logic [PERIOD_W-1:0]   step_period;
    logic [NRUNS_W-1:0]    pan_runs;
    logic [NRUNS_W-1:0]    tilt_runs;
    seq_phase_t            phase;
    logic [RUNS_W-1:0]     runs_left;
    logic [RUNS_W-1:0]     tilt_pending;
    logic [ROW_W-1:0]      row;
    logic [COIL_W-1:0]     coil;
    logic [PERIOD_W-1:0]   delay;
    logic                  pan_rev;
    logic                  tilt_rev;
    logic [COIL_COUNT-1:0] pan_drive;
    logic [COIL_COUNT-1:0] tilt_drive;
    result_t               coil_results_q[$];
    int                    errors;
    int                    checked;
    int                    moves;
    int                    refused;

    function new();
      count_limit  = COUNT_LIMIT_RST;
      step_period  = STEP_PERIOD_RST;
      pan_runs     = PAN_RUNS_RST;
      tilt_runs    = TILT_RUNS_RST;
      phase        = SEQ_IDLE;
      runs_left    = '0;
      tilt_pending = '0;
      row          = '0;
      coil         = '0;
      delay        = '0;
      pan_rev      = 1'b0;
      tilt_rev     = 1'b0;
      pan_drive    = '0;
      tilt_drive   = '0;
      errors       = 0;
      checked      = 0;
      moves        = 0;
      refused      = 0;
    endfunction

    function void write_cfg(logic [REG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
      case (idx)
        REG_COUNT_LIMIT: count_limit = val[MAXC_W-1:0];
        REG_STEP_PERIOD: step_period = val;
        REG_PAN_RUNS:    pan_runs    = val[NRUNS_W-1:0];
        REG_TILT_RUNS:   tilt_runs   = val[NRUNS_W-1:0];
      endcase
    endfunction

    function logic busy();
      return phase != SEQ_IDLE;
    endfunction

    function int pending();
      return coil_results_q.size();
    endfunction

    // clamp the magnitude, scale by passes per unit, saturate
    function logic [RUNS_W-1:0] passes(logic [STEPS_W-1:0] steps, logic [NRUNS_W-1:0] runs);
      logic [STEPS_W-1:0]        mag;
      logic [MAXC_W+NRUNS_W-1:0] prod;
      mag = steps[STEPS_W-1] ? (~steps + 1'b1) : steps;
      if (mag > count_limit) mag = count_limit;
      prod = mag[MAXC_W-1:0] * runs;
      return (prod > RUNS_MAX) ? RUNS_MAX : prod[RUNS_W-1:0];
    endfunction

    function void write_slot();
      logic [ROW_W-1:0]      r;
      logic [COIL_COUNT-1:0] pat;
      r = (phase == SEQ_PAN ? pan_rev : tilt_rev) ? ~row : row;
      pat = COIL_PATTERN[4*r +: 4];
      if (phase == SEQ_PAN) pan_drive[coil] = pat[coil];
      else tilt_drive[coil] = pat[coil];
      coil++;
      if (coil == 0) begin
        row++;
        if (row == 0) begin
          runs_left--;
          if (runs_left == 0) begin
            if (phase == SEQ_PAN && tilt_pending != 0) begin
              phase        = SEQ_TILT;
              runs_left    = tilt_pending;
              tilt_pending = '0;
            end else begin
              phase = SEQ_FINISH;
            end
          end
        end
      end
      delay = (step_period == 0) ? '0 : step_period - 1'b1;
    endfunction

    function void note_input(logic act, logic [STEPS_W-1:0] pan, logic [STEPS_W-1:0] tilt);
      logic              done;
      logic              rej;
      logic [RUNS_W-1:0] pp;
      logic [RUNS_W-1:0] tp;
      result_t           res;
      done = 1'b0;
      rej  = 1'b0;
      if (act) begin
        if (phase != SEQ_IDLE) begin
          rej = 1'b1;
        end else begin
          pp         = passes(pan, pan_runs);
          tp         = passes(tilt, tilt_runs);
          pan_rev    = pan[STEPS_W-1];
          tilt_rev   = !tilt[STEPS_W-1];
          pan_drive  = '0;
          tilt_drive = '0;
          row        = '0;
          coil       = '0;
          delay      = '0;
          if (pp != 0) begin
            phase        = SEQ_PAN;
            runs_left    = pp;
            tilt_pending = tp;
          end else if (tp != 0) begin
            phase        = SEQ_TILT;
            runs_left    = tp;
            tilt_pending = '0;
          end else begin
            runs_left    = '0;
            tilt_pending = '0;
            done         = 1'b1;
          end
        end
      end else if (phase != SEQ_IDLE) begin
        if (delay != 0) begin
          delay--;
        end else if (phase == SEQ_FINISH) begin
          pan_drive  = '0;
          tilt_drive = '0;
          phase      = SEQ_IDLE;
          runs_left  = '0;
          row        = '0;
          coil       = '0;
          done       = 1'b1;
        end else begin
          write_slot();
        end
      end
      moves   += done;
      refused += rej;
      res.pan_coils  = pan_drive;
      res.tilt_coils = tilt_drive;
      res.busy       = (phase != SEQ_IDLE);
      res.done       = done;
      res.rejected   = rej;
      coil_results_q.push_back(res);
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (coil_results_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result %h arrived, expected none", $time, got);
        return;
      end
      want = coil_results_q.pop_front();
      checked++;
      compare("pan_coils", want.pan_coils, got.pan_coils);
      compare("tilt_coils", want.tilt_coils, got.tilt_coils);
      compare("busy_res", want.busy, got.busy);
      compare("move_done", want.done, got.done);
      compare("start_rejected", want.rejected, got.rejected);
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       action = 1'b0;
  logic signed [STEPS_W-1:0]  pan_steps = '0;
  logic signed [STEPS_W-1:0]  tilt_steps = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [COIL_COUNT-1:0]      pan_coils;
  logic [COIL_COUNT-1:0]      tilt_coils;
  logic                       busy_res;
  logic                       move_done;
  logic                       start_rejected;
  logic                       wr_en = 1'b0;
  logic [REG_IDX_W-1:0]       wr_index = '0;
  logic [PERIOD_W-1:0]        wr_data = '0;

  coil_scoreboard sb;
  bit             calm = 1'b0;
  int             work_items = 0;
  int             settings = 1;

  pan_tilt_half_step_sequencer i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .pan_steps      (pan_steps),
    .tilt_steps     (tilt_steps),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pan_coils      (pan_coils),
    .tilt_coils     (tilt_coils),
    .busy_res       (busy_res),
    .move_done      (move_done),
    .start_rejected (start_rejected),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data)
  );

  always #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("[pan_tilt_half_step_sequencer] ERROR");
    $finish;
  end

  // outputs only change at the rising edge, so the falling edge sees what the edge takes
  always @(negedge clk) begin
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.pan_coils  = pan_coils;
      got.tilt_coils = tilt_coils;
      got.busy       = busy_res;
      got.done       = move_done;
      got.rejected   = start_rejected;
      sb.check_result(got);
    end
  end

  initial begin
    int cyc;
    cyc = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      cyc++;
      // hold off long enough for the input side to back up
      if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_CYCLES) out_stall <= 1'b1;
      else out_stall <= !calm && ($urandom_range(0, 99) < 21);
    end
  end

  function automatic logic [STEPS_W-1:0] rnd_steps();
    return STEPS_W'($urandom);
  endfunction

  function automatic logic [STEPS_W-1:0] pick_steps(int lim, bit wide);
    int v;
    if (wide && $urandom_range(0, 3) == 0) return rnd_steps();
    v = int'($urandom_range(0, 2 * lim)) - lim;
    return STEPS_W'(v);
  endfunction

  task automatic send_item(input logic act, input logic [STEPS_W-1:0] pan,
                           input logic [STEPS_W-1:0] tilt);
    bit taken;
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    pan_steps  <= pan;
    tilt_steps <= tilt;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (act || sb.busy()) work_items++;
    sb.note_input(act, pan, tilt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    sb.write_cfg(idx, val);
  endtask

  task automatic set_config(input int maxc, input int period, input int pan_r, input int tilt_r);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    put_reg(REG_COUNT_LIMIT, PERIOD_W'(maxc));
    put_reg(REG_STEP_PERIOD, PERIOD_W'(period));
    put_reg(REG_PAN_RUNS, PERIOD_W'(pan_r));
    put_reg(REG_TILT_RUNS, PERIOD_W'(tilt_r));
    wr_en <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // tick until the move ends; now and then a start that must be refused
  task automatic run_to_idle();
    while (sb.busy())
      send_item($urandom_range(0, 99) < 3, rnd_steps(), rnd_steps());
  endtask

  task automatic move(input logic [STEPS_W-1:0] pan, input logic [STEPS_W-1:0] tilt);
    send_item(1'b1, pan, tilt);
    run_to_idle();
  endtask

  task automatic random_phase(input int maxc, input int period, input int pan_r,
                              input int tilt_r, input int lim, input bit wide, input int quota);
    int stop_at;
    set_config(maxc, period, pan_r, tilt_r);
    stop_at = work_items + quota;
    while (work_items < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1:    send_item(1'b0, rnd_steps(), rnd_steps());
        2:       drain();
        default: move(pick_steps(lim, wide), pick_steps(lim, wide));
      endcase
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: idle tick and an empty move
    send_item(1'b0, 16'sh7FFF, -16'sd1);
    send_item(1'b1, 16'sd0, 16'sd0);

    // default clamp and passes per unit with fast stepping, tilt-only move
    set_config(10, 1, 8, 4);
    move(16'sd0, -16'sd1);

    // zero step period, clamp at both field extremes, each direction
    set_config(1, 0, 1, 1);
    move(16'sh8000, 16'sh7FFF);
    move(16'sh7FFF, 16'sh8000);
    move(16'sd0, 16'sd1);
    move(-16'sd1, 16'sd0);
    send_item(1'b1, 16'sd0, 16'sd0);

    // clamp to zero: every start ends at once
    set_config(0, 1, 16, 16);
    send_item(1'b1, 16'sh8000, 16'sh7FFF);
    send_item(1'b1, 16'sd5, -16'sd5);

    // one axis with no passes
    set_config(2, 2, 0, 1);
    move(16'sd2, -16'sd2);
    set_config(2, 2, 1, 0);
    move(-16'sd2, 16'sd3);

    random_phase(3, 1, 1, 1, 3, 1'b1, 120);
    random_phase(1023, 2, 1, 2, 2, 1'b0, 120);
    random_phase(2, 3, 2, 1, 2, 1'b1, 100);
    calm = 1'b1;
    random_phase(1, 1, 4, 4, 1, 1'b1, 120);
    calm = 1'b0;
    random_phase(5, 0, 1, 1, 5, 1'b1, 120);
    random_phase(0, 65535, 16, 16, 0, 1'b1, 60);

    // slower stepping, single pass on pan
    set_config(1, 4, 1, 1);
    move(-16'sd1, 16'sd0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d transactions over %0d register settings.", sb.checked, settings);
    $display("Finished %0d moves, refused %0d starts while busy.", sb.moves, sb.refused);
    if (sb.errors == 0) begin
      $display("[pan_tilt_half_step_sequencer] OK");
    end else begin
      $display("[pan_tilt_half_step_sequencer] ERROR");
    end
    $finish;
  end

endmodule
